/* rtl/tfpm_pkg.sv */
// types and constants of the thruster force to pwm map
// no dependencies
`timescale 1ns / 1ps
package tfpm_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int LANES       = 4;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int LANE_W      = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int PROD_W      = 34;
   localparam int DVS_W       = 17;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_DRIVE = 1'b1;

   localparam logic [2:0] REG_LANE_SOURCE  = 3'd0;
   localparam logic [2:0] REG_LANE_REVERSE = 3'd1;
   localparam logic [2:0] REG_PWM_OFFSETS  = 3'd2;
   localparam logic [2:0] REG_PWM_MINIMUMS = 3'd3;
   localparam logic [2:0] REG_PWM_MAXIMUMS = 3'd4;
   localparam logic [2:0] REG_ENTRIES      = 3'd5;

   typedef struct packed {
      logic               kind;
      logic [7:0]         entry_index;
      logic signed [15:0] entry_force;
      logic signed [15:0] entry_pwm;
      logic signed [15:0] force_0;
      logic signed [15:0] force_1;
      logic signed [15:0] force_2;
      logic signed [15:0] force_3;
   } req_type;

   typedef struct packed {
      logic signed [15:0] pwm_0;
      logic signed [15:0] pwm_1;
      logic signed [15:0] pwm_2;
      logic signed [15:0] pwm_3;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [DVS_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* rtl/thruster_force_to_pwm_map.sv */
// thruster force to pwm map: table memory, lane sequencer, register port
// depends on tfpm_pkg and tfpm_div
//
//  channel   direction  handshake          payload
//  req       in         req_valid/stall    req_data (req_type)
//  rsp       out        rsp_valid/stall    rsp_data (rsp_type)
//  csr       in/out     psel/penable       paddr, pwdata, prdata
//
// a load item is written to the table at its transfer; a drive item runs each lane in turn
// through a pick, reads of the first and last entries, a scan of one table entry per step
// up to the last entry in use, and a multiply and bit-serial division when it interpolates;
// no new item is taken until the result of a drive item is registered
// reset is synchronous; the table holds no reset value and needs no sweep
// a finished result waits in the output register while load items go on
`timescale 1ns / 1ps
module thruster_force_to_pwm_map
   import tfpm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_PICK = 8'b0000_0010,
      S_LO   = 8'b0000_0100,
      S_HI   = 8'b0000_1000,
      S_SCAN = 8'b0001_0000,
      S_MUL  = 8'b0010_0000,
      S_DIV  = 8'b0100_0000,
      S_ADD  = 8'b1000_0000
   } state_type;

   // configuration registers
   logic [7:0]  lane_source_ff;
   logic [3:0]  lane_reverse_ff;
   logic [63:0] pwm_offsets_ff, pwm_minimums_ff, pwm_maximums_ff;
   logic [8:0]  entries_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = paddr[5:3];
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_source_ff  <= 8'd228;
         lane_reverse_ff <= '0;
         pwm_offsets_ff  <= '0;
         pwm_minimums_ff <= '0;
         pwm_maximums_ff <= '0;
         entries_ff      <= 9'd2;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_LANE_SOURCE:  lane_source_ff  <= pwdata[7:0];
            REG_LANE_REVERSE: lane_reverse_ff <= pwdata[3:0];
            REG_PWM_OFFSETS:  pwm_offsets_ff  <= pwdata;
            REG_PWM_MINIMUMS: pwm_minimums_ff <= pwdata;
            REG_PWM_MAXIMUMS: pwm_maximums_ff <= pwdata;
            REG_ENTRIES:      entries_ff      <= pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_LANE_SOURCE:  prdata = {56'd0, lane_source_ff};
         REG_LANE_REVERSE: prdata = {60'd0, lane_reverse_ff};
         REG_PWM_OFFSETS:  prdata = pwm_offsets_ff;
         REG_PWM_MINIMUMS: prdata = pwm_minimums_ff;
         REG_PWM_MAXIMUMS: prdata = pwm_maximums_ff;
         REG_ENTRIES:      prdata = {55'd0, entries_ff};
         default:          prdata = '0;
      endcase
   end

   // effective entry count, clamped to 2..TABLE_DEPTH
   logic [IDX_W-1:0] last_idx;
   always_comb begin
      if (entries_ff < 9'd2)
         last_idx = IDX_W'(1);
      else if ({23'd0, entries_ff} > 32'(TABLE_DEPTH))
         last_idx = IDX_W'(TABLE_DEPTH - 1);
      else
         last_idx = IDX_W'(entries_ff - 9'd1);
   end

   // table memory: force in the upper half, pwm in the lower
   logic [31:0]      table_mem [TABLE_DEPTH];
   logic [31:0]      rdata_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_wr;
   logic signed [15:0] rd_force, rd_pwm;

   assign rd_force = rdata_ff[31:16];
   assign rd_pwm   = rdata_ff[15:0];

   always_ff @(posedge clock) begin
      if (mem_wr)
         table_mem[req_data.entry_index[IDX_W-1:0]] <= {req_data.entry_force, req_data.entry_pwm};
      rdata_ff <= table_mem[rd_addr];
   end

   // sequencer
   state_type          state_ff, state_in;
   logic [LANE_W-1:0]  lane_ff, lane_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic signed [15:0] forces_ff [4];
   logic signed [15:0] f_ff, f_in;
   logic signed [15:0] prev_force_ff, prev_force_in;
   logic signed [15:0] prev_pwm_ff, prev_pwm_in;
   logic signed [16:0] dp_ff, dp_in, dx_ff, dx_in;
   logic [DVS_W-1:0]   df_ff, df_in;
   logic               neg_ff, neg_in;
   logic signed [18:0] res_ff, res_in;
   logic signed [15:0] lane_out_ff [4];
   logic signed [15:0] lane_out_in;
   logic               out_we;
   rsp_type            rsp_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               room, accept, last_lane;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic signed [15:0] f_sel, f_rev;
   logic [1:0]         src;
   logic signed [16:0] df_s;
   logic [16:0]        dp_mag, dx_mag;
   logic signed [18:0] q_s;
   logic signed [19:0] v_sum;
   logic signed [15:0] off_l, min_l, max_l;

   assign room      = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign mem_wr    = accept && (req_data.kind == KIND_LOAD)
                      && ({24'd0, req_data.entry_index} < 32'(TABLE_DEPTH));
   assign last_lane = (lane_ff == LANE_W'(LANES - 1));

   assign src   = lane_source_ff[2*lane_ff +: 2];
   assign f_sel = forces_ff[src];
   assign f_rev = (f_sel == -16'sd32768) ? 16'sd32767 : -f_sel;
   assign df_s  = 17'(rd_force) - 17'(prev_force_ff);
   assign dp_mag = dp_ff[16] ? 17'(-dp_ff) : 17'(dp_ff);
   assign dx_mag = dx_ff[16] ? 17'(-dx_ff) : 17'(dx_ff);
   assign q_s   = neg_ff ? -19'(div_rsp.quotient[18:0]) : 19'(div_rsp.quotient[18:0]);
   assign off_l = pwm_offsets_ff[16*lane_ff +: 16];
   assign min_l = pwm_minimums_ff[16*lane_ff +: 16];
   assign max_l = pwm_maximums_ff[16*lane_ff +: 16];
   assign v_sum = 20'(res_ff) + 20'(off_l);

   always_comb begin
      if (v_sum < 20'(min_l))
         lane_out_in = min_l;
      else if (v_sum > 20'(max_l))
         lane_out_in = max_l;
      else
         lane_out_in = v_sum[15:0];
   end

   always_comb begin
      state_in      = state_ff;
      lane_in       = lane_ff;
      k_in          = k_ff;
      f_in          = f_ff;
      prev_force_in = prev_force_ff;
      prev_pwm_in   = prev_pwm_ff;
      dp_in         = dp_ff;
      dx_in         = dx_ff;
      df_in         = df_ff;
      neg_in        = neg_ff;
      res_in        = res_ff;
      rd_addr       = '0;
      out_we        = 1'b0;
      div_req       = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            lane_in = '0;
            if (accept && (req_data.kind == KIND_DRIVE))
               state_in = S_PICK;
         end
         S_PICK: begin
            f_in     = lane_reverse_ff[lane_ff] ? f_rev : f_sel;
            state_in = S_LO;
         end
         S_LO: begin
            prev_force_in = rd_force;
            prev_pwm_in   = rd_pwm;
            rd_addr       = last_idx;
            if (f_ff <= rd_force) begin
               res_in   = 19'(rd_pwm);
               state_in = S_ADD;
            end else begin
               state_in = S_HI;
            end
         end
         S_HI: begin
            rd_addr = IDX_W'(1);
            k_in    = IDX_W'(1);
            if (f_ff >= rd_force) begin
               res_in   = 19'(rd_pwm);
               state_in = S_ADD;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if ((k_ff < last_idx) && (rd_force < f_ff)) begin
               prev_force_in = rd_force;
               prev_pwm_in   = rd_pwm;
               k_in          = k_ff + 1'b1;
               rd_addr       = k_ff + 1'b1;
            end else if (df_s <= 17'sd0) begin
               res_in   = 19'(prev_pwm_ff);
               state_in = S_ADD;
            end else begin
               dp_in    = 17'(rd_pwm) - 17'(prev_pwm_ff);
               dx_in    = 17'(f_ff) - 17'(prev_force_ff);
               df_in    = DVS_W'(df_s);
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // magnitudes go to the divider, the sign is put back afterwards
            div_req.start    = 1'b1;
            div_req.dividend = PROD_W'(dp_mag) * PROD_W'(dx_mag);
            div_req.divisor  = df_ff;
            neg_in           = dp_ff[16] ^ dx_ff[16];
            state_in         = S_DIV;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               res_in   = 19'(prev_pwm_ff) + q_s;
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            if (!last_lane) begin
               out_we   = 1'b1;
               lane_in  = lane_ff + 1'b1;
               state_in = S_PICK;
            end else if (room) begin
               out_we       = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   tfpm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lane_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lane_ff      <= lane_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff          <= k_in;
      f_ff          <= f_in;
      prev_force_ff <= prev_force_in;
      prev_pwm_ff   <= prev_pwm_in;
      dp_ff         <= dp_in;
      dx_ff         <= dx_in;
      df_ff         <= df_in;
      neg_ff        <= neg_in;
      res_ff        <= res_in;
      if (accept && (req_data.kind == KIND_DRIVE)) begin
         forces_ff[0] <= req_data.force_0;
         forces_ff[1] <= req_data.force_1;
         forces_ff[2] <= req_data.force_2;
         forces_ff[3] <= req_data.force_3;
      end
      if (out_we)
         lane_out_ff[lane_ff] <= lane_out_in;
      if (out_we && last_lane) begin
         rsp_data_ff.pwm_0 <= (LANES > 0) ? ((lane_ff == LANE_W'(0)) ? lane_out_in
                                                                       : lane_out_ff[0]) : '0;
         rsp_data_ff.pwm_1 <= (LANES > 1) ? ((lane_ff == LANE_W'(1)) ? lane_out_in
                                                                       : lane_out_ff[1]) : '0;
         rsp_data_ff.pwm_2 <= (LANES > 2) ? ((lane_ff == LANE_W'(2)) ? lane_out_in
                                                                       : lane_out_ff[2]) : '0;
         rsp_data_ff.pwm_3 <= (LANES > 3) ? ((lane_ff == LANE_W'(3)) ? lane_out_in
                                                                       : lane_out_ff[3]) : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/tfpm_div.sv */
// restoring unsigned divider, one quotient bit per cycle
// depends on tfpm_pkg
`timescale 1ns / 1ps
module tfpm_div
   import tfpm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(PROD_W + 1);

   logic [PROD_W-1:0] quot_ff, quot_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DVS_W:0]    rem_sh;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, quot_ff[PROD_W-1]};
      if (div_req.start) begin
         quot_in = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = CNT_W'(PROD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in  = DVS_W'(rem_sh - {1'b0, dvs_ff});
            quot_in = {quot_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[DVS_W-1:0];
            quot_in = {quot_ff[PROD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

/* rtl/tfpm_checker.sv */
// port checker for the thruster force to pwm map, bound to the top level
// depends on tfpm_pkg
`timescale 1ns / 1ps
module tfpm_checker
   import tfpm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data,
   input logic    pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("rsp valid dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data)) else $error("rsp data changed");

   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.kind == KIND_DRIVE) |=> req_stall)
      else $error("drive transfer not followed by busy");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("rsp valid after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready) else $error("pready low");

endmodule

bind thruster_force_to_pwm_map tfpm_checker u_tfpm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .pready    (pready)
);

/* tb/thruster_force_to_pwm_map_tb.sv */
// self-checking testbench of the thruster force to pwm map
// depends on tfpm_pkg and the thruster_force_to_pwm_map rtl
`timescale 1ns / 1ps
module thruster_force_to_pwm_map_tb;
   import tfpm_pkg::*;

   localparam int DRAIN_CYCLES = 4 * (TABLE_DEPTH + 42) + 100;
   localparam int CYCLE_LIMIT  = 3000000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [5:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;

   thruster_force_to_pwm_map dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // shadow of the block's registers and table
   logic [7:0]         sh_source;
   logic [3:0]         sh_reverse;
   logic [63:0]        sh_offsets;
   logic [63:0]        sh_minimums;
   logic [63:0]        sh_maximums;
   logic [8:0]         sh_entries;
   logic signed [15:0] sh_force [TABLE_DEPTH];
   logic signed [15:0] sh_pwm   [TABLE_DEPTH];

   rsp_type pwm_expected [$];
   int      mismatch_count;
   int      cycle_count;
   int      hold_cycles;
   bit      idle_on;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int table_lookup(int f);
      int  n;
      int  k;
      longint dp, dx, df;
      n = sh_entries;
      if (n < 2) n = 2;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      if (f <= sh_force[0]) return sh_pwm[0];
      if (f >= sh_force[n-1]) return sh_pwm[n-1];
      k = 1;
      while (k < n - 1 && sh_force[k] < f) k++;
      dp = longint'(sh_pwm[k]) - sh_pwm[k-1];
      dx = longint'(f) - sh_force[k-1];
      df = longint'(sh_force[k]) - sh_force[k-1];
      if (df <= 0) return sh_pwm[k-1];
      return int'(longint'(sh_pwm[k-1]) + (dp * dx) / df);
   endfunction

   function automatic rsp_type predict_pwm(req_type it);
      int f_in [4];
      int res  [4];
      int f, v, lo, hi;
      rsp_type r;
      f_in[0] = it.force_0;
      f_in[1] = it.force_1;
      f_in[2] = it.force_2;
      f_in[3] = it.force_3;
      for (int l = 0; l < 4; l++) begin
         if (l >= LANES) begin
            res[l] = 0;
         end else begin
            f = f_in[sh_source[2*l +: 2]];
            if (sh_reverse[l]) f = (f == -32768) ? 32767 : -f;
            v = table_lookup(f) + int'($signed(sh_offsets[16*l +: 16]));
            lo = $signed(sh_minimums[16*l +: 16]);
            hi = $signed(sh_maximums[16*l +: 16]);
            if (v < lo) v = lo;
            else if (v > hi) v = hi;
            res[l] = v;
         end
      end
      r.pwm_0 = res[0][15:0];
      r.pwm_1 = res[1][15:0];
      r.pwm_2 = res[2][15:0];
      r.pwm_3 = res[3][15:0];
      return r;
   endfunction

   task automatic send_item(req_type it);
      if (idle_on && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      if (it.kind == KIND_LOAD) begin
         sh_force[it.entry_index] = it.entry_force;
         sh_pwm[it.entry_index]   = it.entry_pwm;
      end else begin
         pwm_expected.insert(pwm_expected.size(), predict_pwm(it));
      end
   endtask

   task automatic send_load(int idx, int f, int p);
      req_type it;
      it.kind        = KIND_LOAD;
      it.entry_index = idx[7:0];
      it.entry_force = f[15:0];
      it.entry_pwm   = p[15:0];
      it.force_0     = 16'($urandom);
      it.force_1     = 16'($urandom);
      it.force_2     = 16'($urandom);
      it.force_3     = 16'($urandom);
      send_item(it);
   endtask

   task automatic send_drive(int f0, int f1, int f2, int f3);
      req_type it;
      it.kind        = KIND_DRIVE;
      it.entry_index = 8'($urandom);
      it.entry_force = 16'($urandom);
      it.entry_pwm   = 16'($urandom);
      it.force_0     = f0[15:0];
      it.force_1     = f1[15:0];
      it.force_2     = f2[15:0];
      it.force_3     = f3[15:0];
      send_item(it);
   endtask

   // sender stops and waits out every result, then the block's worst latency
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pwm_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_LANE_SOURCE:  sh_source   = value[7:0];
         REG_LANE_REVERSE: sh_reverse  = value[3:0];
         REG_PWM_OFFSETS:  sh_offsets  = value;
         REG_PWM_MINIMUMS: sh_minimums = value;
         REG_PWM_MAXIMUMS: sh_maximums = value;
         REG_ENTRIES:      sh_entries  = value[8:0];
         default: ;
      endcase
   endtask

   // ascending table of n entries over most of the force range
   task automatic load_ramp(int n);
      int step;
      int p;
      step = 60000 / n;
      p = -20000;
      for (int i = 0; i < n; i++) begin
         send_load(i, -30000 + i * step, p);
         p += $urandom_range(0, 4000) - 1000;
      end
   endtask

   function automatic logic [63:0] four_lanes(int a, int b, int c, int d);
      return {d[15:0], c[15:0], b[15:0], a[15:0]};
   endfunction

   task automatic open_limits();
      csr_write(REG_PWM_MINIMUMS, {4{16'h8000}});
      csr_write(REG_PWM_MAXIMUMS, {4{16'h7fff}});
   endtask

   task automatic test_reset_defaults();
      // limits reset to zero, so all pins read zero
      load_ramp(TABLE_DEPTH);
      send_drive(0, 100, -100, 32767);
      wait_drained();
   endtask

   task automatic test_table_edges();
      open_limits();
      csr_write(REG_ENTRIES, 64'(9'd4));
      send_load(0, -1000, -500);
      send_load(1, 0, 0);
      send_load(2, 1000, 700);
      send_load(3, 2000, 32767);
      send_drive(-32768, 32767, -1000, 2000);
      send_drive(-1001, 2001, 0, 1000);
      send_drive(-999, 1, 999, 1999);
      send_drive(-500, 500, 1500, -1);
      // a repeated force gives a zero-width segment
      send_load(1, -1000, 300);
      send_drive(-999, -1000, 5, 1999);
      wait_drained();
   endtask

   task automatic test_lane_config();
      csr_write(REG_LANE_SOURCE, 64'(8'b00_01_10_11));
      csr_write(REG_LANE_REVERSE, 64'(4'b1111));
      send_drive(-32768, 32767, 1500, -700);
      wait_drained();
      csr_write(REG_LANE_SOURCE, 64'(8'h00));
      csr_write(REG_LANE_REVERSE, 64'(4'b0101));
      send_drive(-32768, 1, 2, 3);
      wait_drained();
      csr_write(REG_PWM_OFFSETS, four_lanes(32767, -32768, 1000, -1000));
      send_drive(1999, -999, 500, 32767);
      wait_drained();
   endtask

   task automatic test_limits();
      // crossed limits: below min gives min, anything else max
      csr_write(REG_PWM_MINIMUMS, four_lanes(100, -32768, 32767, 0));
      csr_write(REG_PWM_MAXIMUMS, four_lanes(-100, 32767, -32768, 0));
      send_drive(-32768, 0, 32767, 1500);
      send_drive(32767, -32768, 0, -1);
      wait_drained();
      csr_write(REG_PWM_OFFSETS, 64'h0);
      open_limits();
      wait_drained();
   endtask

   task automatic test_entry_count();
      logic [8:0] counts [5] = '{9'd0, 9'd1, 9'd256, 9'd511, 9'd300};
      foreach (counts[i]) begin
         csr_write(REG_ENTRIES, 64'(counts[i]));
         send_drive(-32768, 32767, $urandom, $urandom);
         send_drive($urandom, $urandom, $urandom, $urandom);
         wait_drained();
      end
   endtask

   task automatic random_config();
      int n;
      csr_write(REG_LANE_SOURCE, 64'($urandom));
      csr_write(REG_LANE_REVERSE, 64'($urandom));
      if ($urandom_range(1)) csr_write(REG_PWM_OFFSETS, {$urandom, $urandom});
      else csr_write(REG_PWM_OFFSETS, four_lanes($urandom_range(0, 2000) - 1000,
         $urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
         $urandom_range(0, 2000) - 1000));
      if ($urandom_range(3) == 0) begin
         csr_write(REG_PWM_MINIMUMS, {$urandom, $urandom});
         csr_write(REG_PWM_MAXIMUMS, {$urandom, $urandom});
      end else begin
         csr_write(REG_PWM_MINIMUMS, four_lanes(-$urandom_range(0, 32768),
            -$urandom_range(0, 32768), -$urandom_range(0, 32768),
            -$urandom_range(0, 32768)));
         csr_write(REG_PWM_MAXIMUMS, four_lanes($urandom_range(0, 32767),
            $urandom_range(0, 32767), $urandom_range(0, 32767),
            $urandom_range(0, 32767)));
      end
      n = $urandom_range(2, 10);
      csr_write(REG_ENTRIES, 64'(n));
      if ($urandom_range(1)) load_ramp(n);
   endtask

   function automatic int pick_force();
      if ($urandom_range(1)) return $urandom_range(0, 64000) - 32000;
      return $signed($urandom_range(0, 65535) - 32768);
   endfunction

   task automatic random_items(int count);
      int n;
      for (int i = 0; i < count; i++) begin
         n = sh_entries < 2 ? 2 : sh_entries;
         if ($urandom_range(99) < 15) begin
            if ($urandom_range(3) == 0) send_load($urandom_range(0, 255),
               $urandom, $urandom);
            else send_load($urandom_range(0, n - 1), pick_force(), $urandom);
         end else begin
            send_drive(pick_force(), pick_force(), pick_force(), pick_force());
         end
      end
   endtask

   task automatic test_random();
      for (int ph = 0; ph < 6; ph++) begin
         idle_on = (ph != 2);
         random_config();
         random_items(250);
         wait_drained();
      end
      idle_on = 1'b1;
   endtask

   task automatic test_backpressure();
      hold_cycles = 3000;
      for (int i = 0; i < 40; i++) send_drive(pick_force(), pick_force(), 0, -1);
      wait_drained();
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pwm_expected.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result transfer %h", rsp_data);
         end else begin
            rsp_type want;
            want = pwm_expected.pop_front();
            if (rsp_data.pwm_0 !== want.pwm_0 || rsp_data.pwm_1 !== want.pwm_1 ||
                rsp_data.pwm_2 !== want.pwm_2 || rsp_data.pwm_3 !== want.pwm_3) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("pwm mismatch: expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                     want.pwm_0, want.pwm_1, want.pwm_2, want.pwm_3,
                     rsp_data.pwm_0, rsp_data.pwm_1, rsp_data.pwm_2, rsp_data.pwm_3);
            end
         end
      end
   end

   // receiver stall, with a long hold-off counted down here
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < 35);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      mismatch_count = 0;
      cycle_count = 0;
      hold_cycles = 0;
      idle_on = 1'b1;
      sh_source = 8'd228;
      sh_reverse = '0;
      sh_offsets = '0;
      sh_minimums = '0;
      sh_maximums = '0;
      sh_entries = 9'd2;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_table_edges();
      test_lane_config();
      test_limits();
      test_entry_count();
      test_random();
      test_backpressure();
      wait_drained();
      if (mismatch_count == 0 && pwm_expected.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
